FILE: hdl/morton_quadrant_op_unit_macros.svh
// Assertion macros used by the RTL core.
`ifndef MORTON_QUADRANT_OP_UNIT_MACROS_SVH
`define MORTON_QUADRANT_OP_UNIT_MACROS_SVH

`define MQO_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define MQO_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/mqo_pkg.sv
`timescale 1ns / 1ps
package mqo_pkg;

   localparam int CodeW  = 63;
   localparam int LevelW = 5;
   localparam int AxisW  = 21;

   typedef enum logic [3:0] {
      CMD_PARENT     = 4'd0,
      CMD_CHILD      = 4'd1,
      CMD_ANCESTOR   = 4'd2,
      CMD_FIRST_DESC = 4'd3,
      CMD_LAST_DESC  = 4'd4,
      CMD_SUCC       = 4'd5,
      CMD_PRED       = 4'd6,
      CMD_COMPARE    = 4'd7,
      CMD_IS_ANC     = 4'd8,
      CMD_IS_PARENT  = 4'd9,
      CMD_ANC_ID     = 4'd10,
      CMD_NCA        = 4'd11,
      CMD_LIN_ID     = 4'd12,
      CMD_FROM_LIN   = 4'd13,
      CMD_AXES       = 4'd14,
      CMD_VALID      = 4'd15
   } cmd_type;

   typedef struct packed {
      cmd_type             cmd;
      logic [CodeW-1:0]    code_a;
      logic [LevelW-1:0]   level_a;
      logic [CodeW-1:0]    code_b;
      logic [LevelW-1:0]   level_b;
      logic [LevelW-1:0]   target_level;
      logic [2:0]          child_index;
      logic [CodeW-1:0]    linear_index;
   } req_type;

   typedef struct packed {
      logic [CodeW-1:0]    res_code;
      logic [LevelW-1:0]   res_level;
      logic signed [1:0]   answer;
      logic [CodeW-1:0]    res_index;
      logic [AxisW-1:0]    axis_x;
      logic [AxisW-1:0]    axis_y;
      logic [AxisW-1:0]    axis_z;
      logic                error;
   } rsp_type;

endpackage

FILE: hdl/morton_quadrant_op_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Content
// req_      in         one operation: command and operands
// rsp_      out        one result per operation
// One transaction enters per cycle unless the output is full and rsp_tready is low.
// The depth is set by four register stages: masks, operations, leading-one search, output.
// Reset is synchronous and active high; it clears only the stage valid bits.
// A stall on rsp_tready freezes the whole pipeline; nothing is dropped or repeated.
module morton_quadrant_op_unit #(
   parameter int DIM        = 3,
   parameter int TREE_DEPTH = 21,
   parameter int CELL_DEPTH = 20
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // cmd, code_a, level_a, code_b, level_b, target_level, child_index, linear_index, pad
   input  logic [215:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // res_code, res_level, answer, res_index, axis_x, axis_y, axis_z, error, pad
   output logic [199:0] rsp_tdata
);
   import mqo_pkg::*;

   req_type r;
   rsp_type o;
   logic    adv;

   assign r.cmd          = cmd_type'(req_tdata[3:0]);
   assign r.code_a       = req_tdata[66:4];
   assign r.level_a      = req_tdata[71:67];
   assign r.code_b       = req_tdata[134:72];
   assign r.level_b      = req_tdata[139:135];
   assign r.target_level = req_tdata[144:140];
   assign r.child_index  = req_tdata[147:145];
   assign r.linear_index = req_tdata[210:148];

   assign adv        = rsp_tready || !rsp_tvalid;
   assign req_tready = adv;

   mqo_core #(.DIM(DIM), .TREE_DEPTH(TREE_DEPTH), .CELL_DEPTH(CELL_DEPTH)) u_core (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(req_tvalid),
      .in_req(r), .out_valid(rsp_tvalid), .out_rsp(o)
   );

   assign rsp_tdata = {3'd0, o.error, o.axis_z, o.axis_y, o.axis_x, o.res_index,
                       o.answer, o.res_level, o.res_code};
endmodule

FILE: hdl/mqo_core.sv
`timescale 1ns / 1ps
`include "morton_quadrant_op_unit_macros.svh"
module mqo_core #(
   parameter int DIM        = 3,
   parameter int TREE_DEPTH = 21,
   parameter int CELL_DEPTH = 20
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            adv,
   input  logic            in_valid,
   input  mqo_pkg::req_type in_req,
   output logic            out_valid,
   output mqo_pkg::rsp_type out_rsp
);
   import mqo_pkg::*;

   localparam int RootBits = DIM * TREE_DEPTH;
   localparam logic [63:0] DigitMask = (64'd1 << DIM) - 64'd1;

   // Stage 1: masks and validity.
   typedef struct packed {
      req_type           r;
      logic [63:0]       pa;     // place(1, la)
      logic [63:0]       pt;     // place(1, tl)
      logic [63:0]       pa1;    // place(1, la + 1)
      logic [63:0]       pb;     // place(1, lb)
      logic [5:0]        sha;
      logic [5:0]        sht;
      logic              va;
      logic              vb;
   } s1_type;

   typedef struct packed {
      req_type           r;
      logic              va;
      logic              vb;
      logic              err;
      logic [63:0]       rc;
      logic [LevelW-1:0] rl;
      logic signed [1:0] ans;
      logic [63:0]       idx;
      logic [63:0]       x;
      logic [5:0]        sht;
   } s2_type;

   typedef struct packed {
      s2_type            s;
      logic [6:0]        grp;
      logic              any;
   } s3_type;

   logic   v1_ff, v2_ff, v3_ff, v4_ff;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   rsp_type s4_ff, s4_in;

   function automatic logic [5:0] shift_of(input logic [LevelW-1:0] lev);
      logic [5:0] s;
      s = 6'd0;
      if (int'(lev) <= TREE_DEPTH) s = 6'(DIM * (TREE_DEPTH - int'(lev)));
      return s;
   endfunction

   function automatic logic [63:0] place1(input logic [LevelW-1:0] lev);
      logic [63:0] p;
      p = 64'd0;
      if (int'(lev) <= TREE_DEPTH) p = 64'd1 << shift_of(lev);
      return p;
   endfunction

   function automatic logic cell_ok(input logic [62:0] c, input logic [LevelW-1:0] lev);
      logic ok;
      ok = (int'(lev) <= CELL_DEPTH) && ((({1'b0, c}) & (place1(lev) - 64'd1)) == 64'd0)
           && (({1'b0, c} >> RootBits) == 64'd0);
      return ok;
   endfunction

   always_comb begin
      s1_in.r   = in_req;
      s1_in.pa  = place1(in_req.level_a);
      s1_in.pt  = place1(in_req.target_level);
      s1_in.pa1 = place1(in_req.level_a + 5'd1);
      s1_in.pb  = place1(in_req.level_b);
      s1_in.sha = shift_of(in_req.level_a);
      s1_in.sht = shift_of(in_req.target_level);
      s1_in.va  = cell_ok(in_req.code_a, in_req.level_a);
      s1_in.vb  = cell_ok(in_req.code_b, in_req.level_b);
   end

   // Stage 2: operations except the leading-one search and the common-ancestor and axis results.
   always_comb begin
      logic [63:0] ca, cb, lin, t;
      logic        va, vb;
      logic [LevelW-1:0] la, lb, tl;
      ca = {1'b0, s1_ff.r.code_a};
      cb = {1'b0, s1_ff.r.code_b};
      lin = {1'b0, s1_ff.r.linear_index};
      la = s1_ff.r.level_a;
      lb = s1_ff.r.level_b;
      tl = s1_ff.r.target_level;
      va = s1_ff.va;
      vb = s1_ff.vb;
      t  = 64'd0;
      s2_in = '0;
      s2_in.r = s1_ff.r;
      s2_in.va = va;
      s2_in.vb = vb;
      s2_in.sht = s1_ff.sht;
      s2_in.x = ca ^ cb;
      unique case (s1_ff.r.cmd)
         CMD_PARENT: begin
            if (!va || la == '0) s2_in.err = 1'b1;
            else begin
               s2_in.rc = ca & ~(s1_ff.pa * DigitMask);
               s2_in.rl = la - 5'd1;
            end
         end
         CMD_CHILD: begin
            if (!va || int'(la) >= CELL_DEPTH || 64'(s1_ff.r.child_index) > DigitMask)
               s2_in.err = 1'b1;
            else begin
               s2_in.rc = ca | ({64{s1_ff.r.child_index[0]}} & s1_ff.pa1)
                             | ({64{s1_ff.r.child_index[1]}} & (s1_ff.pa1 << 1))
                             | ({64{s1_ff.r.child_index[2]}} & (s1_ff.pa1 << 2));
               s2_in.rl = la + 5'd1;
            end
         end
         CMD_ANCESTOR: begin
            if (!va || tl >= la) s2_in.err = 1'b1;
            else begin
               s2_in.rc = ca & ~(s1_ff.pt - 64'd1);
               s2_in.rl = tl;
            end
         end
         CMD_FIRST_DESC, CMD_LAST_DESC: begin
            if (!va || tl < la || int'(tl) > CELL_DEPTH) s2_in.err = 1'b1;
            else begin
               s2_in.rc = ca;
               if (s1_ff.r.cmd == CMD_LAST_DESC) s2_in.rc = ca | (s1_ff.pa - s1_ff.pt);
               s2_in.rl = tl;
            end
         end
         CMD_SUCC: begin
            t = ca + s1_ff.pa;
            if (!va || (t >> RootBits) != 64'd0) s2_in.err = 1'b1;
            else begin
               s2_in.rc = t;
               s2_in.rl = la;
            end
         end
         CMD_PRED: begin
            if (!va || ca == 64'd0) s2_in.err = 1'b1;
            else begin
               s2_in.rc = ca - s1_ff.pa;
               s2_in.rl = la;
            end
         end
         CMD_COMPARE: begin
            if (!va || !vb) s2_in.err = 1'b1;
            else s2_in.ans = (ca == cb) ? 2'sd0 : ((ca > cb) ? 2'sd1 : -2'sd1);
         end
         CMD_IS_ANC: begin
            if (!va || !vb) s2_in.err = 1'b1;
            else if (la < lb && ((ca ^ cb) >> s1_ff.sha) == 64'd0) s2_in.ans = 2'sd1;
         end
         CMD_IS_PARENT: begin
            if (!va || !vb) s2_in.err = 1'b1;
            else if ((la + 5'd1) == lb && ca == (cb & ~(s1_ff.pb * DigitMask)))
               s2_in.ans = 2'sd1;
         end
         CMD_ANC_ID: begin
            if (!va || tl > la) s2_in.err = 1'b1;
            else if (tl != '0) s2_in.idx = (ca & (s1_ff.pt * DigitMask)) >> s1_ff.sht;
         end
         CMD_NCA: begin
            if (!va || !vb) s2_in.err = 1'b1;
         end
         CMD_LIN_ID: begin
            if (!va || int'(tl) > TREE_DEPTH) s2_in.err = 1'b1;
            else s2_in.idx = ca >> s1_ff.sht;
         end
         CMD_FROM_LIN: begin
            if (int'(tl) > CELL_DEPTH
                || (lin >> (6'(DIM) * 6'(tl))) != 64'd0) s2_in.err = 1'b1;
            else begin
               s2_in.rc = lin << s1_ff.sht;
               s2_in.rl = tl;
            end
         end
         CMD_AXES: begin
            if (!va) s2_in.err = 1'b1;
         end
         CMD_VALID: begin
            s2_in.ans = va ? 2'sd1 : 2'sd0;
         end
         default: s2_in.err = 1'b1;
      endcase
   end

   // Stage 3: leading-one detect on the XOR of the codes, as a digit count.
   always_comb begin
      s3_in.s = s2_ff;
      s3_in.grp = '0;
      s3_in.any = 1'b0;
      for (int k = 0; k < 64; k++) begin
         if (s2_ff.x[k]) begin
            s3_in.grp = 7'(k / DIM + 1);
            s3_in.any = 1'b1;
         end
      end
   end

   // Stage 4: common ancestor and coordinates, error clearing.
   always_comb begin
      logic [63:0] ca;
      logic [LevelW-1:0] lo, rl;
      logic [6:0] grp;
      ca = {1'b0, s3_ff.s.r.code_a};
      lo = (s3_ff.s.r.level_a < s3_ff.s.r.level_b) ? s3_ff.s.r.level_a : s3_ff.s.r.level_b;
      grp = s3_ff.grp;
      rl = '0;
      s4_in = '0;
      s4_in.error = s3_ff.s.err;
      if (!s3_ff.s.err) begin
         s4_in.res_code  = s3_ff.s.rc[62:0];
         s4_in.res_level = s3_ff.s.rl;
         s4_in.answer    = s3_ff.s.ans;
         s4_in.res_index = s3_ff.s.idx[62:0];
         if (s3_ff.s.r.cmd == CMD_NCA) begin
            if (!s3_ff.any) begin
               s4_in.res_code  = s3_ff.s.r.code_a;
               s4_in.res_level = lo;
            end else begin
               s4_in.res_code = 63'(ca & ~((64'd1 << (7'(DIM) * grp)) - 64'd1));
               rl = 5'(TREE_DEPTH - int'(grp));
               s4_in.res_level = (lo < rl) ? lo : rl;
            end
         end
         if (s3_ff.s.r.cmd == CMD_AXES) begin
            for (int i = 0; i < TREE_DEPTH; i++) begin
               s4_in.axis_x[i] = ca[DIM * i];
               s4_in.axis_y[i] = ca[DIM * i + 1];
               if (DIM == 3) s4_in.axis_z[i] = ca[DIM * i + DIM - 1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_rsp   = s4_ff;

   `MQO_ASSERT_NEXT(a_stall_holds, clock, reset, !adv && v4_ff, v4_ff && $stable(s4_ff), "stalled result changed")
   `MQO_ASSERT_IMPL(a_err_clears, clock, reset, v4_ff && s4_ff.error, s4_ff.res_code == '0 && s4_ff.answer == '0, "error result not cleared")
   `MQO_ASSERT_NEXT(a_flow, clock, reset, adv && v3_ff, v4_ff, "item lost between stages")
endmodule
